FILE: hw/rtl/cnrf_pkg.sv
// ----------------------------------------------------------------------------
// cnrf_pkg
// Shared widths, register indexes and payload types of the root finder.
// ----------------------------------------------------------------------------
package cnrf_pkg;

	localparam int MaxDegree = 4;
	localparam int FracBits  = 16;
	localparam int NumCoef   = MaxDegree + 1;
	localparam int StopScale = 10000;

	// register indexes
	localparam logic [2:0] REG_COEF_LAST = 3'd4;
	localparam logic [2:0] REG_MAX_ITERS = 3'd5;

	localparam logic [3:0] ITERS_RESET = 4'd4;

	typedef struct packed {
		logic signed [31:0] interval_low;
		logic signed [31:0] interval_high;
	} cnrf_in_t;

	typedef struct packed {
		logic signed [31:0] chord_root;
		logic signed [31:0] newton_root;
		logic signed [31:0] mean_root;
		logic [3:0]         chord_steps;
		logic [3:0]         newton_steps;
		logic               fixed_end_high;
		logic               divide_fault;
	} cnrf_out_t;

	// saturate a 66-bit value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -66'sh0_8000_0000) return -32'sh8000_0000;
		return v[31:0];
	endfunction

endpackage

FILE: hw/rtl/cnrf_if.sv
// ----------------------------------------------------------------------------
// cnrf_in_if / cnrf_out_if
// Valid/ready channels of the root finder.
// ----------------------------------------------------------------------------
interface cnrf_in_if import cnrf_pkg::*; ();
	logic     valid;
	logic     ready;
	cnrf_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cnrf_out_if import cnrf_pkg::*; ();
	logic      valid;
	logic      ready;
	cnrf_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cnrf_div.sv
// ----------------------------------------------------------------------------
// cnrf_div
// Restoring signed divider, 66-bit dividend by 34-bit divisor, one quotient
// bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module cnrf_div import cnrf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [65:0] num,
	input  logic signed [33:0] den,
	output logic               done,
	output logic signed [65:0] quo
);

	logic [65:0] q_q;
	logic [65:0] r_q;
	logic [65:0] d_q;
	logic        neg_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [65:0] r_sh;

	assign r_sh = {r_q[64:0], q_q[65]};
	assign quo  = neg_q ? -$signed(q_q) : $signed(q_q);

	// one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd66;
				q_q    <= num[65] ? 66'(-num) : 66'(num);
				d_q    <= den[33] ? 66'(-{{32{den[33]}}, den}) : 66'({{32{1'b0}}, den});
				r_q    <= '0;
				neg_q  <= num[65] ^ den[33];
			end else if (busy_q) begin
				if (r_sh >= d_q) begin
					r_q <= r_sh - d_q;
					q_q <= {q_q[64:0], 1'b1};
				end else begin
					r_q <= r_sh;
					q_q <= {q_q[64:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/chord_newton_root_finder.sv
// ----------------------------------------------------------------------------
// chord_newton_root_finder
// Chord plus Newton root finding of a degree-4 Q16.16 polynomial.
//
// channel  dir  fields
// in_ch    in   interval_low, interval_high
// out_ch   out  chord_root, newton_root, mean_root, steps, flags
//
// One item at a time. A Horner evaluation uses the shared multiplier, and the
// chord and Newton steps divide on the shared divider; each loop runs up to
// 15 steps (4 at the reset limit). arst_n clears the sequencer; the result holds
// in its register until taken, and the next item is taken after that.
// ----------------------------------------------------------------------------
module chord_newton_root_finder import cnrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	cnrf_in_if.sink     in_ch,
	cnrf_out_if.source  out_ch
);

	typedef enum logic [3:0] {
		S_IDLE, S_FA, S_FPPA, S_BRANCH, S_FFIX, S_FX, S_DEN, S_DIV, S_DIVW,
		S_UPD, S_DONE
	} state_t;

	typedef enum logic [1:0] { P_F, P_D1, P_D2 } poly_t;

	state_t             state_q;
	logic signed [31:0] coef_q [NumCoef];
	logic [3:0]         iters_q;
	logic signed [31:0] d1 [NumCoef];
	logic signed [31:0] d2 [NumCoef];

	logic signed [31:0] a_q, b_q, fa_q, ffix_q, fixed_q, xold_q, fx_q, den_q;
	logic signed [31:0] xc_q;
	logic               newton_q, neg_q, fault_q;
	logic [3:0]         step_q, cs_q, lim;
	logic [2:0]         hk_q;
	logic               hbusy_q;
	poly_t              hsel_q;
	logic signed [31:0] hx_q, acc_q;
	logic signed [63:0] prod;
	logic signed [31:0] hc;
	logic               dstart;
	logic signed [65:0] dnum, dquo, qcl;
	logic signed [33:0] dden;
	logic               ddone;
	logic signed [31:0] xnew;
	logic signed [47:0] k_old, k_new;
	logic signed [32:0] msum;
	cnrf_out_t          res_q;

	// derivative coefficients
	always_comb begin
		for (int k = 0; k < NumCoef; k++) begin
			d1[k] = '0;
			d2[k] = '0;
		end
		for (int k = 0; k < MaxDegree; k++)
			d1[k] = sat32(66'(coef_q[k + 1]) * 66'(k + 1));
		for (int k = 0; k < MaxDegree; k++)
			d2[k] = sat32(66'(d1[k + 1]) * 66'(k + 1));
	end

	// coefficient mux for the Horner unit
	always_comb begin
		case (hsel_q)
			P_D1:    hc = d1[hk_q];
			P_D2:    hc = d2[hk_q];
			default: hc = coef_q[hk_q];
		endcase
	end

	assign prod = acc_q * hx_q;
	assign lim  = (iters_q == 4'd0) ? 4'd1 : iters_q;

	// divide operands and clamped quotient
	assign dnum = newton_q ? 66'(fx_q) <<< FracBits
	                       : 66'(fx_q) * 66'(34'(xold_q) - 34'(fixed_q));
	assign dden = newton_q ? 34'(den_q) : 34'(fx_q) - 34'(ffix_q);
	assign qcl  = (dquo > 66'sd17179869184) ? 66'sd17179869184 :
	              (dquo < -66'sd17179869184) ? -66'sd17179869184 : dquo;
	assign xnew = sat32(66'(xold_q) - qcl);

	// stop keys, trunc(x*10000/2^16)
	function automatic logic signed [47:0] skey(input logic signed [31:0] x);
		logic signed [47:0] p;
		p = 48'(x) * 48'sd10000;
		return (p + (p[47] ? 48'sd65535 : 48'sd0)) >>> FracBits;
	endfunction
	assign k_old = skey(xold_q);
	assign k_new = skey(xnew);
	assign msum  = 33'(xc_q) + 33'(xold_q);

	cnrf_div u_div (
		.clk, .arst_n, .start(dstart), .num(dnum), .den(dden),
		.done(ddone), .quo(dquo)
	);

	assign in_ch.ready  = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_DONE);
	assign out_ch.data  = res_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NumCoef; k++) coef_q[k] <= '0;
			iters_q <= ITERS_RESET;
		end else if (cfg_we) begin
			if (cfg_index <= REG_COEF_LAST) coef_q[cfg_index] <= cfg_data;
			else if (cfg_index == REG_MAX_ITERS) iters_q <= cfg_data[3:0];
		end
	end

	// sequencer and Horner unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hbusy_q <= 1'b0;
			dstart  <= 1'b0;
		end else begin
			dstart <= 1'b0;
			if (hbusy_q) begin
				acc_q <= sat32(66'(prod >>> FracBits) + 66'(hc));
				hk_q  <= hk_q - 3'd1;
				if (hk_q == 3'd0) hbusy_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (in_ch.valid) begin
					a_q     <= in_ch.data.interval_low;
					b_q     <= in_ch.data.interval_high;
					fault_q <= 1'b0;
					hsel_q  <= P_F; hx_q <= in_ch.data.interval_low;
					acc_q   <= coef_q[MaxDegree]; hk_q <= 3'(MaxDegree - 1);
					hbusy_q <= 1'b1;
					state_q <= S_FA;
				end
				S_FA: if (!hbusy_q) begin
					fa_q   <= acc_q;
					hsel_q <= P_D2; acc_q <= d2[MaxDegree]; hk_q <= 3'(MaxDegree - 1);
					hbusy_q <= 1'b1;
					state_q <= S_FPPA;
				end
				S_FPPA: if (!hbusy_q) begin
					neg_q   <= (fa_q != 0) && (acc_q != 0) && (fa_q[31] != acc_q[31]);
					state_q <= S_BRANCH;
				end
				S_BRANCH: begin
					// chord loop first
					newton_q <= 1'b0;
					step_q   <= '0;
					xold_q   <= neg_q ? a_q : b_q;
					fixed_q  <= neg_q ? b_q : a_q;
					hsel_q   <= P_F; hx_q <= neg_q ? b_q : a_q;
					acc_q    <= coef_q[MaxDegree]; hk_q <= 3'(MaxDegree - 1);
					hbusy_q  <= 1'b1;
					state_q  <= S_FFIX;
				end
				S_FFIX: if (!hbusy_q) begin
					ffix_q  <= acc_q;
					hsel_q  <= P_F; hx_q <= xold_q;
					acc_q   <= coef_q[MaxDegree]; hk_q <= 3'(MaxDegree - 1);
					hbusy_q <= 1'b1;
					step_q  <= step_q + 4'd1;
					state_q <= S_FX;
				end
				S_FX: if (!hbusy_q) begin
					fx_q <= acc_q;
					if (newton_q) begin
						hsel_q <= P_D1; acc_q <= d1[MaxDegree]; hk_q <= 3'(MaxDegree - 1);
						hbusy_q <= 1'b1;
						state_q <= S_DEN;
					end else state_q <= S_DIV;
				end
				S_DEN: if (!hbusy_q) begin
					den_q   <= acc_q;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (dden == 34'sd0) begin
						fault_q <= 1'b1;
						state_q <= S_UPD;
					end else begin
						dstart  <= 1'b1;
						state_q <= S_DIVW;
					end
				end
				S_DIVW: if (ddone) begin
					if (k_new == k_old || step_q == lim) state_q <= S_UPD;
					else begin
						xold_q <= xnew;
						hsel_q <= P_F; hx_q <= xnew;
						acc_q  <= coef_q[MaxDegree]; hk_q <= 3'(MaxDegree - 1);
						hbusy_q <= 1'b1;
						step_q <= step_q + 4'd1;
						state_q <= S_FX;
					end
					if (k_new == k_old || step_q == lim) xold_q <= xnew;
				end
				S_UPD: begin
					// loop finished; xold_q holds its estimate
					if (!newton_q) begin
						xc_q     <= xold_q;
						cs_q     <= step_q;
						newton_q <= 1'b1;
						step_q   <= 4'd1;
						xold_q   <= neg_q ? b_q : a_q;
						hsel_q   <= P_F; hx_q <= neg_q ? b_q : a_q;
						acc_q    <= coef_q[MaxDegree]; hk_q <= 3'(MaxDegree - 1);
						hbusy_q  <= 1'b1;
						state_q  <= S_FX;
					end else begin
						res_q.chord_root     <= xc_q;
						res_q.newton_root    <= xold_q;
						res_q.mean_root      <= 32'((msum + (msum[32] ? 33'sd1 : 33'sd0)) >>> 1);
						res_q.chord_steps    <= cs_q;
						res_q.newton_steps   <= step_q;
						res_q.fixed_end_high <= neg_q;
						res_q.divide_fault   <= fault_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of chord_newton_root_finder. A short table of intervals
// runs first: rows after reset carry typed results, later rows go through
// the root predictor. Then random polynomial phases with random intervals,
// random source gaps and sink stalls. Every output transfer is checked
// field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb;
	import cnrf_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam longint     ONE_Q      = 64'sd1 << FracBits;
	localparam int         NUM_PHASES = 10;
	localparam int         PHASE_LEN  = 100;

	// directed setups applied before a row
	typedef enum int {
		SETUP_NONE,
		SETUP_SQRT2,
		SETUP_CUBIC_ZERO_LIMIT,
		SETUP_COEF_MAX
	} setup_t;

	typedef struct {
		setup_t             setup;
		logic signed [31:0] a;
		logic signed [31:0] b;
		bit                 typed;
		cnrf_out_t          res;
	} interval_row_t;

	logic clk;
	logic arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	cnrf_in_if  in_ch ();
	cnrf_out_if out_ch ();

	chord_newton_root_finder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// bench copy of the registers
	longint    poly_coef [0:4];
	logic [3:0] iter_limit;

	cnrf_out_t pending_roots [$];
	int        mismatches;
	bit        gaps_on;

	// directed rows; zero polynomial after reset faults in both loops at once
	interval_row_t interval_rows [17] = '{
		'{SETUP_NONE, 32'sd0, 32'sd0, 1'b1,
			'{32'sd0, 32'sd0, 32'sd0, 4'd1, 4'd1, 1'b0, 1'b1}},
		'{SETUP_NONE, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1,
			'{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, 4'd1, 4'd1, 1'b0, 1'b1}},
		'{SETUP_NONE, 32'sd65536, -32'sd65536, 1'b1,
			'{-32'sd65536, 32'sd65536, 32'sd0, 4'd1, 4'd1, 1'b0, 1'b1}},
		'{SETUP_NONE, 32'sh8000_0000, 32'sh8000_0000, 1'b1,
			'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 4'd1, 4'd1, 1'b0, 1'b1}},
		// x^2 - 2, full limit
		'{SETUP_SQRT2, 32'sd65536, 32'sd131072, 1'b0, '0},
		'{SETUP_NONE, 32'sd131072, 32'sd65536, 1'b0, '0},
		'{SETUP_NONE, -32'sd131072, -32'sd65536, 1'b0, '0},
		'{SETUP_NONE, 32'sd0, 32'sd0, 1'b0, '0},
		'{SETUP_NONE, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, '0},
		'{SETUP_NONE, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, '0},
		'{SETUP_NONE, 32'sd98304, 32'sd98304, 1'b0, '0},
		// x^3 - x, limit zero counts as one
		'{SETUP_CUBIC_ZERO_LIMIT, 32'sd32768, 32'sd131072, 1'b0, '0},
		'{SETUP_NONE, -32'sd131072, -32'sd32768, 1'b0, '0},
		'{SETUP_NONE, 32'sd0, 32'sd65536, 1'b0, '0},
		'{SETUP_NONE, 32'sd65536, 32'sd65536, 1'b0, '0},
		// every coefficient at its maximum, saturating Horner
		'{SETUP_COEF_MAX, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, '0},
		'{SETUP_NONE, 32'sh8000_0000, 32'sh8000_0000, 1'b0, '0}
	};

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------
	// root predictor
	// ------------------------------------------------------------------
	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Horner with floor shifts and saturation at every step
	function automatic longint poly_at(input longint c [0:4], input longint x);
		longint acc;
		acc = c[MaxDegree];
		for (int k = MaxDegree - 1; k >= 0; k--)
			acc = clip32(((acc * x) >>> FracBits) + c[k]);
		return acc;
	endfunction

	function automatic void derive_coefs(input longint src [0:4], output longint dst [0:4]);
		for (int k = 0; k < MaxDegree; k++)
			dst[k] = clip32(longint'(k + 1) * src[k + 1]);
		dst[MaxDegree] = 0;
	endfunction

	function automatic longint settle_key(input longint x);
		return (x * StopScale) / ONE_Q;
	endfunction

	// one loop: chord toward the fixed end, or Newton with derivative slope
	function automatic longint refine_root(input bit newton, input longint start,
			input longint fixed_end, input longint slope [0:4], input int limit,
			output int steps, inout bit fault);
		longint x_old, x_new, f_fix, fx, num, den, q;
		x_old = start;
		x_new = start;
		f_fix = poly_at(poly_coef, fixed_end);
		steps = 0;
		for (int i = 0; i < limit; i++) begin
			fx = poly_at(poly_coef, x_old);
			steps++;
			if (newton) begin
				den = poly_at(slope, x_old);
				num = fx * ONE_Q;
			end else begin
				den = fx - f_fix;
				num = fx * (x_old - fixed_end);
			end
			if (den == 0) begin
				fault = 1'b1;
				x_new = x_old;
				break;
			end
			q = num / den;
			if (q > (64'sd1 << 34)) q = 64'sd1 << 34;
			if (q < -(64'sd1 << 34)) q = -(64'sd1 << 34);
			x_new = clip32(x_old - q);
			if (settle_key(x_new) == settle_key(x_old))
				break;
			x_old = x_new;
		end
		return x_new;
	endfunction

	function automatic cnrf_out_t predict_roots(input logic signed [31:0] a_in,
			input logic signed [31:0] b_in);
		longint    d1 [0:4];
		longint    d2 [0:4];
		longint    a, b, fa, fppa, xc, xn;
		int        limit, cs, ns;
		bit        fault, neg;
		cnrf_out_t r;
		a = a_in;
		b = b_in;
		fault = 1'b0;
		limit = (iter_limit == 0) ? 1 : int'(iter_limit);
		derive_coefs(poly_coef, d1);
		derive_coefs(d1, d2);
		fa = poly_at(poly_coef, a);
		fppa = poly_at(d2, a);
		neg = (fa != 0) && (fppa != 0) && ((fa < 0) != (fppa < 0));
		if (neg) begin
			xc = refine_root(1'b0, a, b, d1, limit, cs, fault);
			xn = refine_root(1'b1, b, b, d1, limit, ns, fault);
		end else begin
			xc = refine_root(1'b0, b, a, d1, limit, cs, fault);
			xn = refine_root(1'b1, a, a, d1, limit, ns, fault);
		end
		r.chord_root = xc[31:0];
		r.newton_root = xn[31:0];
		r.mean_root = 32'((xc + xn) / 2);
		r.chord_steps = cs[3:0];
		r.newton_steps = ns[3:0];
		r.fixed_end_high = neg;
		r.divide_fault = fault;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// register writes; caller ends a burst with end_writes
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx <= REG_COEF_LAST)
			poly_coef[idx] = longint'(signed'(value));
		else if (idx == REG_MAX_ITERS)
			iter_limit = value[3:0];
		@(posedge clk);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_poly(input longint c [0:4], input logic [3:0] limit);
		for (int k = 0; k <= MaxDegree; k++)
			write_reg(k[2:0], c[k][31:0]);
		write_reg(REG_MAX_ITERS, {28'd0, limit});
		write_reg(REG_UNUSED, $urandom);
		end_writes();
	endtask

	// ------------------------------------------------------------------
	// source side
	// ------------------------------------------------------------------
	task automatic send_interval(input logic signed [31:0] a, input logic signed [31:0] b,
			input bit typed, input cnrf_out_t typed_res);
		int gap;
		cnrf_in_t item;
		gap = gaps_on ? $urandom_range(0, 11) : 0;
		item.interval_low = a;
		item.interval_high = b;
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data <= item;
		do @(posedge clk); while (!in_ch.ready);
		pending_roots.push_back(typed ? typed_res : predict_roots(a, b));
	endtask

	// drop valid and wait until every result has come back
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_roots.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_q(input int span);
		return $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic signed [31:0] rand_interval_end();
		if ($urandom_range(0, 4) == 0) return $urandom;
		return rand_q(16 << FracBits);
	endfunction

	// stimulus
	initial begin
		longint     c [0:4];
		logic [3:0] limit;
		int         kind;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		mismatches = 0;
		gaps_on = 1'b1;
		for (int k = 0; k <= MaxDegree; k++) poly_coef[k] = 0;
		iter_limit = ITERS_RESET;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (interval_rows[i]) begin
			if (interval_rows[i].setup != SETUP_NONE) begin
				drain();
				for (int k = 0; k <= MaxDegree; k++) c[k] = 0;
				case (interval_rows[i].setup)
					SETUP_SQRT2: begin
						c[0] = -2 * ONE_Q;
						c[2] = ONE_Q;
						limit = 4'd15;
					end
					SETUP_CUBIC_ZERO_LIMIT: begin
						c[1] = -ONE_Q;
						c[3] = ONE_Q;
						limit = 4'd0;
					end
					default: begin
						for (int k = 0; k <= MaxDegree; k++) c[k] = 64'sd2147483647;
						limit = 4'd1;
					end
				endcase
				load_poly(c, limit);
			end
			send_interval(interval_rows[i].a, interval_rows[i].b,
				interval_rows[i].typed, interval_rows[i].res);
		end

		// random phases, each with a fresh polynomial and limit
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			kind = $urandom_range(0, 3);
			for (int k = 0; k <= MaxDegree; k++) begin
				case (kind)
					0: c[k] = rand_q(4 << FracBits);
					1: c[k] = longint'(signed'($urandom));
					2: c[k] = ($urandom_range(0, 1) != 0) ? rand_q(8 << FracBits) : 0;
					default: c[k] = (k <= 2) ? rand_q(3 << FracBits) : 0;
				endcase
			end
			case (p)
				0: limit = 4'd15;
				1: limit = 4'd0;
				2: limit = 4'd1;
				default: limit = 4'($urandom_range(0, 15));
			endcase
			load_poly(c, limit);
			for (int i = 0; i < PHASE_LEN; i++) begin
				if (i % 25 == 0) gaps_on = ($urandom_range(0, 2) != 0);
				send_interval(rand_interval_end(), rand_interval_end(), 1'b0, '0);
			end
		end

		drain();
		repeat (50) @(negedge clk);
		if (mismatches == 0 && pending_roots.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------
	// sink side: random stalls, check each transfer
	// ------------------------------------------------------------------
	initial begin
		int        stall;
		bit        stalls_on;
		cnrf_out_t got, want;
		out_ch.ready = 1'b0;
		stalls_on = 1'b1;
		@(posedge arst_n);
		@(negedge clk);
		out_ch.ready <= 1'b1;
		forever begin
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
			got = out_ch.data;
			if (pending_roots.size() == 0) begin
				$error("unexpected result transfer");
				mismatches++;
			end else begin
				want = pending_roots.pop_front();
				if (got.chord_root !== want.chord_root) begin
					$error("chord_root: expected %0d, got %0d", want.chord_root, got.chord_root);
					mismatches++;
				end
				if (got.newton_root !== want.newton_root) begin
					$error("newton_root: expected %0d, got %0d",
						want.newton_root, got.newton_root);
					mismatches++;
				end
				if (got.mean_root !== want.mean_root) begin
					$error("mean_root: expected %0d, got %0d", want.mean_root, got.mean_root);
					mismatches++;
				end
				if (got.chord_steps !== want.chord_steps) begin
					$error("chord_steps: expected %0d, got %0d",
						want.chord_steps, got.chord_steps);
					mismatches++;
				end
				if (got.newton_steps !== want.newton_steps) begin
					$error("newton_steps: expected %0d, got %0d",
						want.newton_steps, got.newton_steps);
					mismatches++;
				end
				if (got.fixed_end_high !== want.fixed_end_high) begin
					$error("fixed_end_high: expected %0b, got %0b",
						want.fixed_end_high, got.fixed_end_high);
					mismatches++;
				end
				if (got.divide_fault !== want.divide_fault) begin
					$error("divide_fault: expected %0b, got %0b",
						want.divide_fault, got.divide_fault);
					mismatches++;
				end
			end
			if ($urandom_range(0, 31) == 0) stalls_on = !stalls_on;
			stall = stalls_on ? $urandom_range(0, 11) : 0;
			if (stall > 0) begin
				@(negedge clk);
				out_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
				@(negedge clk);
				out_ch.ready <= 1'b1;
			end
		end
	end

	// run limit
	initial begin
		#100_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/cnrf_pkg.sv
hw/rtl/cnrf_if.sv
hw/rtl/cnrf_div.sv
hw/rtl/chord_newton_root_finder.sv
sim/tb.sv
